@@ sv/iuc_pkg.sv @@
// Shared definitions for the centred integer upscaler.
// Holds widths, limits, register indexes and the sequencer state type.
// No dependencies.
`default_nettype none

package iuc_pkg;

	localparam int DimW   = 13;
	localparam int PosW   = 12;
	localparam int ScaleW = 4;
	localparam int StepW  = 3;
	localparam int AccW   = 14;
	localparam int AddrW  = 24;
	localparam int ColorW = 32;
	localparam int IdxW   = 2;

	localparam logic [DimW-1:0]   MaxDim   = 13'd4096;
	localparam logic [ScaleW-1:0] MaxScale = 4'd8;

	typedef logic [DimW-1:0]        dim_t;
	typedef logic signed [DimW-1:0] coord_t;
	typedef logic [PosW-1:0]        pos_t;
	typedef logic [ScaleW-1:0]      scale_t;
	typedef logic [StepW-1:0]       step_t;

	// configuration register indexes
	typedef enum logic [IdxW-1:0] {
		REG_SRC_W = 2'd0,
		REG_SRC_H = 2'd1,
		REG_DST_W = 2'd2,
		REG_DST_H = 2'd3
	} reg_idx_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_SEARCH,
		ST_OFFSET,
		ST_EMIT
	} state_t;

	// saturate a written dimension at the largest supported size
	function automatic dim_t sat_dim(input dim_t v);
		sat_dim = (v > MaxDim) ? MaxDim : v;
	endfunction

endpackage

`default_nettype wire

@@ sv/integer_upscale_centered.sv @@
// Centred integer nearest-neighbour upscaler, top level.
// Depends on iuc_pkg for widths, limits, register indexes and state type.
//
// Usage:
//  - Source pixels enter on pixel_color (in_valid/in_ready) in raster order.
//    Each one yields scale x scale target writes, row by row, on the output
//    channel (out_valid/out_ready), one transaction per cycle when the
//    receiver keeps out_ready high.
//  - With a zero dimension configured, each pixel yields a single result
//    with dim_error set and all other fields zero.
//  - Configuration: pulse cfg_write with cfg_index/cfg_data. Values above
//    4096 are saturated. After each write the scale is stepped up from 1
//    to at most 8 by an add/compare on each axis, one compare a cycle,
//    then the offset state works out the centring offsets; the frame
//    position restarts at the first pixel. in_ready stays low after a
//    write until the sequencer is back in idle.
//  - Pixels are accepted only in idle, so a new pixel waits until the single
//    write sequencer has issued every write of the current one; the first
//    write passes through the EMIT state and the output register. in_ready is low while a pixel is being expanded.
//  - A stalled receiver holds the output register and freezes the sequencer.
//  - Reset clears the control, geometry and position registers, sets the
//    scale to 1 and empties the output; colour and output fields are not reset.
`default_nettype none

module integer_upscale_centered (
	input  wire                          clk,
	input  wire                          arst_n,
	// configuration
	input  wire                          cfg_write,
	input  wire [iuc_pkg::IdxW-1:0]      cfg_index,
	input  wire [iuc_pkg::DimW-1:0]      cfg_data,
	// source pixels
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire [iuc_pkg::ColorW-1:0]    pixel_color,
	// target writes
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic signed [iuc_pkg::DimW-1:0] out_x,
	output logic signed [iuc_pkg::DimW-1:0] out_y,
	output logic [iuc_pkg::AddrW-1:0]    out_address,
	output logic [iuc_pkg::ColorW-1:0]   out_color,
	output logic                         write_valid,
	output logic                         last_of_pixel,
	output logic                         frame_done,
	output logic                         dim_error
);

	iuc_pkg::state_t state_q, state_d;

	// configuration registers
	iuc_pkg::dim_t src_w_q, src_h_q, dst_w_q, dst_h_q;

	// derived geometry
	iuc_pkg::scale_t           scale_q;
	logic [iuc_pkg::AccW-1:0]  acc_w_q, acc_h_q;
	iuc_pkg::coord_t           off_col_q, off_row_q;

	// frame position and per-pixel block origin
	iuc_pkg::pos_t   col_q, row_q;
	iuc_pkg::coord_t x0_q, y0_q;

	// write sequencer
	iuc_pkg::step_t             dx_q, dy_q;
	logic [iuc_pkg::ColorW-1:0] color_q;

	logic out_valid_q;

	// combinational helpers
	logic                      dims_bad;
	logic [iuc_pkg::AccW-1:0]  cand_w, cand_h;
	logic                      can_grow;
	logic signed [iuc_pkg::AccW-1:0] diff_w, diff_h;
	iuc_pkg::coord_t           off_col_d, off_row_d;
	iuc_pkg::step_t            last_step;
	logic                      dx_last, dy_last, blk_last;
	logic                      col_last, row_last;
	iuc_pkg::coord_t           cur_x, cur_y;
	logic                      cur_in;
	logic [iuc_pkg::DimW+iuc_pkg::PosW-1:0] row_base;
	logic [iuc_pkg::AddrW-1:0] cur_addr;
	logic                      out_free;
	logic                      accept;
	logic                      emit_fire;

	assign dims_bad = (src_w_q == '0) || (src_h_q == '0) ||
	                  (dst_w_q == '0) || (dst_h_q == '0);

	// scale search: try one step larger on both axes
	assign cand_w   = acc_w_q + {1'b0, src_w_q};
	assign cand_h   = acc_h_q + {1'b0, src_h_q};
	assign can_grow = (scale_q < iuc_pkg::MaxScale) &&
	                  (cand_w <= {1'b0, dst_w_q}) && (cand_h <= {1'b0, dst_h_q});

	// centring offsets, halved with truncation toward zero
	assign diff_w    = $signed({1'b0, dst_w_q}) - $signed(acc_w_q);
	assign diff_h    = $signed({1'b0, dst_h_q}) - $signed(acc_h_q);
	assign off_col_d = iuc_pkg::coord_t'((diff_w + {{(iuc_pkg::AccW-1){1'b0}},
	                   diff_w[iuc_pkg::AccW-1] & diff_w[0]}) >>> 1);
	assign off_row_d = iuc_pkg::coord_t'((diff_h + {{(iuc_pkg::AccW-1){1'b0}},
	                   diff_h[iuc_pkg::AccW-1] & diff_h[0]}) >>> 1);

	// position within the scale x scale block
	assign last_step = iuc_pkg::step_t'(scale_q - 4'd1);
	assign dx_last   = (dx_q == last_step);
	assign dy_last   = (dy_q == last_step);
	assign blk_last  = dx_last && dy_last;
	assign col_last  = ({1'b0, col_q} + 13'd1) >= src_w_q;
	assign row_last  = ({1'b0, row_q} + 13'd1) >= src_h_q;

	// current write coordinates and address
	assign cur_x    = x0_q + iuc_pkg::coord_t'({1'b0, dx_q});
	assign cur_y    = y0_q + iuc_pkg::coord_t'({1'b0, dy_q});
	assign cur_in   = !cur_x[iuc_pkg::DimW-1] && !cur_y[iuc_pkg::DimW-1] &&
	                  (iuc_pkg::dim_t'(cur_x) < dst_w_q) &&
	                  (iuc_pkg::dim_t'(cur_y) < dst_h_q);
	assign row_base = cur_y[iuc_pkg::PosW-1:0] * dst_w_q;
	assign cur_addr = row_base[iuc_pkg::AddrW-1:0] +
	                  {{(iuc_pkg::AddrW-iuc_pkg::PosW){1'b0}}, cur_x[iuc_pkg::PosW-1:0]};

	assign out_free  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		if (cfg_write) begin
			state_d = iuc_pkg::ST_INIT;
		end else begin
			unique case (state_q)
				iuc_pkg::ST_IDLE: begin
					if (in_valid) state_d = iuc_pkg::ST_EMIT;
				end
				iuc_pkg::ST_INIT: begin
					state_d = dims_bad ? iuc_pkg::ST_IDLE : iuc_pkg::ST_SEARCH;
				end
				iuc_pkg::ST_SEARCH: begin
					if (!can_grow) state_d = iuc_pkg::ST_OFFSET;
				end
				iuc_pkg::ST_OFFSET: begin
					state_d = iuc_pkg::ST_IDLE;
				end
				iuc_pkg::ST_EMIT: begin
					if (out_free && (dims_bad || blk_last)) state_d = iuc_pkg::ST_IDLE;
				end
				default: state_d = iuc_pkg::ST_IDLE;
			endcase
		end
	end

	// sequencer outputs
	always_comb begin
		in_ready  = (state_q == iuc_pkg::ST_IDLE) && !cfg_write;
		emit_fire = (state_q == iuc_pkg::ST_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iuc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= '0;
			src_h_q <= '0;
			dst_w_q <= '0;
			dst_h_q <= '0;
		end else if (cfg_write) begin
			unique case (iuc_pkg::reg_idx_t'(cfg_index))
				iuc_pkg::REG_SRC_W: src_w_q <= iuc_pkg::sat_dim(cfg_data);
				iuc_pkg::REG_SRC_H: src_h_q <= iuc_pkg::sat_dim(cfg_data);
				iuc_pkg::REG_DST_W: dst_w_q <= iuc_pkg::sat_dim(cfg_data);
				iuc_pkg::REG_DST_H: dst_h_q <= iuc_pkg::sat_dim(cfg_data);
				default: ;
			endcase
		end
	end

	// geometry and frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q   <= 4'd1;
			acc_w_q   <= '0;
			acc_h_q   <= '0;
			off_col_q <= '0;
			off_row_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
			x0_q      <= '0;
			y0_q      <= '0;
		end else if (!cfg_write) begin
			unique case (state_q)
				iuc_pkg::ST_INIT: begin
					scale_q   <= 4'd1;
					acc_w_q   <= {1'b0, src_w_q};
					acc_h_q   <= {1'b0, src_h_q};
					off_col_q <= '0;
					off_row_q <= '0;
					col_q     <= '0;
					row_q     <= '0;
					x0_q      <= '0;
					y0_q      <= '0;
				end
				iuc_pkg::ST_SEARCH: begin
					if (can_grow) begin
						scale_q <= scale_q + 4'd1;
						acc_w_q <= cand_w;
						acc_h_q <= cand_h;
					end
				end
				iuc_pkg::ST_OFFSET: begin
					off_col_q <= off_col_d;
					off_row_q <= off_row_d;
					x0_q      <= off_col_d;
					y0_q      <= off_row_d;
				end
				iuc_pkg::ST_EMIT: begin
					// step to the next source pixel after its last write
					if (emit_fire && !dims_bad && blk_last) begin
						if (col_last) begin
							col_q <= '0;
							x0_q  <= off_col_q;
							if (row_last) begin
								row_q <= '0;
								y0_q  <= off_row_q;
							end else begin
								row_q <= row_q + 12'd1;
								y0_q  <= y0_q + iuc_pkg::coord_t'(scale_q);
							end
						end else begin
							col_q <= col_q + 12'd1;
							x0_q  <= x0_q + iuc_pkg::coord_t'(scale_q);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// block step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx_q <= '0;
			dy_q <= '0;
		end else if (accept) begin
			dx_q <= '0;
			dy_q <= '0;
		end else if (emit_fire) begin
			if (dx_last) begin
				dx_q <= '0;
				dy_q <= dy_last ? '0 : dy_q + 3'd1;
			end else begin
				dx_q <= dx_q + 3'd1;
			end
		end
	end

	// latched colour of the pixel being expanded
	always_ff @(posedge clk) begin
		if (accept) color_q <= pixel_color;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			if (dims_bad) begin
				out_x         <= '0;
				out_y         <= '0;
				out_address   <= '0;
				out_color     <= '0;
				write_valid   <= 1'b0;
				last_of_pixel <= 1'b0;
				frame_done    <= 1'b0;
				dim_error     <= 1'b1;
			end else begin
				out_x         <= cur_x;
				out_y         <= cur_y;
				out_address   <= cur_in ? cur_addr : '0;
				out_color     <= color_q;
				write_valid   <= cur_in;
				last_of_pixel <= blk_last;
				frame_done    <= blk_last && col_last && row_last;
				dim_error     <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ tb/integer_upscale_centered_test.sv @@
// Self-checking testbench for integer_upscale_centered: drives source pixels and
// dimension writes, predicts every target write and compares it field by field.
// Depends on iuc_pkg and the integer_upscale_centered RTL.

module integer_upscale_centered_test;
	timeunit 1ns;
	timeprecision 1ps;

	// one expected target write
	typedef struct packed {
		logic [iuc_pkg::DimW-1:0]   col;
		logic [iuc_pkg::DimW-1:0]   row;
		logic [iuc_pkg::AddrW-1:0]  address;
		logic [iuc_pkg::ColorW-1:0] color;
		logic                       write_valid;
		logic                       last_of_pixel;
		logic                       frame_done;
		logic                       dim_error;
	} write_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_write;
	logic [iuc_pkg::IdxW-1:0]      cfg_index;
	logic [iuc_pkg::DimW-1:0]      cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic [iuc_pkg::ColorW-1:0]    pixel_color;
	logic                          out_valid;
	logic                          out_ready;
	logic signed [iuc_pkg::DimW-1:0] out_x;
	logic signed [iuc_pkg::DimW-1:0] out_y;
	logic [iuc_pkg::AddrW-1:0]     out_address;
	logic [iuc_pkg::ColorW-1:0]    out_color;
	logic                          write_valid;
	logic                          last_of_pixel;
	logic                          frame_done;
	logic                          dim_error;

	// predicted dimensions, frame position, scale and centring offsets
	iuc_pkg::dim_t src_w, src_h, dst_w, dst_h;
	int   col_pos, row_pos, scale_cur, off_x, off_y;

	write_t pending_writes[$];
	int     mismatches = 0;
	int     sink_hold = 0;
	bit     quiet_run = 1'b0;

	integer_upscale_centered dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_color  (pixel_color),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_address  (out_address),
		.out_color    (out_color),
		.write_valid  (write_valid),
		.last_of_pixel(last_of_pixel),
		.frame_done   (frame_done),
		.dim_error    (dim_error)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------- prediction

	function automatic bit dims_zero();
		return src_w == 0 || src_h == 0 || dst_w == 0 || dst_h == 0;
	endfunction

	// register write: saturate, store, then rework scale and offsets
	function automatic void apply_dim_write(iuc_pkg::reg_idx_t idx, iuc_pkg::dim_t value);
		iuc_pkg::dim_t v;
		int   sx, sy;
		v = (value > iuc_pkg::MaxDim) ? iuc_pkg::MaxDim : value;
		case (idx)
			iuc_pkg::REG_SRC_W: src_w = v;
			iuc_pkg::REG_SRC_H: src_h = v;
			iuc_pkg::REG_DST_W: dst_w = v;
			iuc_pkg::REG_DST_H: dst_h = v;
		endcase
		col_pos = 0;
		row_pos = 0;
		if (dims_zero()) begin
			scale_cur = 1;
			off_x = 0;
			off_y = 0;
		end else begin
			sx = int'(dst_w) / int'(src_w);
			sy = int'(dst_h) / int'(src_h);
			scale_cur = (sx < sy) ? sx : sy;
			if (scale_cur < 1) scale_cur = 1;
			if (scale_cur > int'(iuc_pkg::MaxScale)) scale_cur = int'(iuc_pkg::MaxScale);
			// SV integer division truncates toward zero, as required
			off_x = (int'(dst_w) - int'(src_w) * scale_cur) / 2;
			off_y = (int'(dst_h) - int'(src_h) * scale_cur) / 2;
		end
	endfunction

	// expand one source pixel into its block of target writes
	function automatic void upscale_pixel(logic [iuc_pkg::ColorW-1:0] color);
		write_t w;
		int     x, y, x0, y0, dx, dy, addr;
		bit     last_col, last_row, in_bounds, last_w;
		w = '0;
		if (dims_zero()) begin
			w.dim_error = 1'b1;
			pending_writes.push_back(w);
			return;
		end
		last_col = col_pos + 1 >= int'(src_w);
		last_row = row_pos + 1 >= int'(src_h);
		x0 = off_x + col_pos * scale_cur;
		y0 = off_y + row_pos * scale_cur;
		for (dy = 0; dy < scale_cur; dy++) begin
			for (dx = 0; dx < scale_cur; dx++) begin
				x = x0 + dx;
				y = y0 + dy;
				in_bounds = x >= 0 && y >= 0 && x < int'(dst_w) && y < int'(dst_h);
				last_w = (dy == scale_cur - 1) && (dx == scale_cur - 1);
				addr = y * int'(dst_w) + x;
				w.col = x[iuc_pkg::DimW-1:0];
				w.row = y[iuc_pkg::DimW-1:0];
				w.address = in_bounds ? addr[iuc_pkg::AddrW-1:0] : '0;
				w.color = color;
				w.write_valid = in_bounds;
				w.last_of_pixel = last_w;
				w.frame_done = last_w && last_col && last_row;
				w.dim_error = 1'b0;
				pending_writes.push_back(w);
			end
		end
		// advance raster position
		if (last_col) begin
			col_pos = 0;
			row_pos = last_row ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endfunction

	// ---------------------------------------------------------------- random helpers

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// dimension: usually small, sometimes zero, large or above the limit
	function automatic iuc_pkg::dim_t pick_dim(int unsigned typical);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 3) return '0;
		if (r < 7) return iuc_pkg::dim_t'($urandom_range(4097, 8191));
		if (r < 11) return iuc_pkg::dim_t'($urandom_range(typical + 1, 4096));
		return iuc_pkg::dim_t'($urandom_range(1, typical));
	endfunction

	// ---------------------------------------------------------------- drivers

	// offer one pixel; returns at the falling edge after acceptance, valid still high
	task automatic send_pixel(logic [iuc_pkg::ColorW-1:0] color);
		int gap;
		gap = (quiet_run || $urandom_range(0, 9) < 4) ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_color <= color;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		upscale_pixel(color);
		@(negedge clk);
	endtask

	// drop valid, let every expected write arrive and the sequencer settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_writes.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(iuc_pkg::reg_idx_t idx, iuc_pkg::dim_t value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		apply_dim_write(idx, value);
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(iuc_pkg::dim_t sw, iuc_pkg::dim_t sh,
	                         iuc_pkg::dim_t tw, iuc_pkg::dim_t th);
		wait_idle();
		write_reg(iuc_pkg::REG_SRC_W, sw);
		write_reg(iuc_pkg::REG_SRC_H, sh);
		write_reg(iuc_pkg::REG_DST_W, tw);
		write_reg(iuc_pkg::REG_DST_H, th);
	endtask

	// ---------------------------------------------------------------- receiver

	// random stalls, plus a long hold-off when a test requests one
	initial begin : receiver
		int stall;
		stall = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				out_ready <= 1'b0;
				sink_hold--;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				if (!quiet_run && $urandom_range(0, 3) == 0) stall = pick_gap();
			end
		end
	end

	// ---------------------------------------------------------------- checking

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// compare each accepted write with the oldest prediction
	always @(posedge clk) begin : check_writes
		write_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_writes.size() == 0) begin
				$display("%0t: unexpected write, expected none, actual x=%0d y=%0d",
					$time, out_x, out_y);
				mismatches++;
			end else begin
				want = pending_writes.pop_front();
				compare_field("out_x", want.col, $unsigned(out_x));
				compare_field("out_y", want.row, $unsigned(out_y));
				compare_field("out_address", want.address, out_address);
				compare_field("out_color", want.color, out_color);
				compare_field("write_valid", want.write_valid, write_valid);
				compare_field("last_of_pixel", want.last_of_pixel, last_of_pixel);
				compare_field("frame_done", want.frame_done, frame_done);
				compare_field("dim_error", want.dim_error, dim_error);
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// after reset every dimension is zero: one error result per pixel
	task automatic test_zero_dims();
		send_pixel('0);
		send_pixel('1);
		wait_idle();
		write_reg(iuc_pkg::REG_SRC_W, 13'd2);
		send_pixel($urandom);
	endtask

	// plain 2x2 into 8x8, one whole frame then the wrap to the first pixel
	task automatic test_basic_upscale();
		configure(13'd2, 13'd2, 13'd8, 13'd8);
		repeat (5) send_pixel($urandom);
	endtask

	// single pixel into the largest target, target dimensions saturated from all ones
	task automatic test_max_scale();
		configure(13'd1, 13'd1, 13'h1fff, 13'h1fff);
		repeat (2) send_pixel($urandom);
	endtask

	// target smaller than source: negative offsets and out-of-range writes
	task automatic test_shrunk_target();
		configure(13'd3, 13'd3, 13'd1, 13'd1);
		repeat (9) send_pixel($urandom);
	endtask

	// a zero-dimension write mid-frame resets the position, which error pixels then hold; a rewrite restarts the frame
	task automatic test_zero_mid_frame();
		configure(13'd3, 13'd1, 13'd10, 13'd30);
		repeat (2) send_pixel($urandom);
		wait_idle();
		write_reg(iuc_pkg::REG_DST_H, '0);
		repeat (2) send_pixel($urandom);
		wait_idle();
		write_reg(iuc_pkg::REG_DST_H, 13'd30);
		repeat (3) send_pixel($urandom);
	endtask

	// receiver holds off while pixels keep coming, so the input stalls
	task automatic test_backpressure();
		configure(13'd2, 13'd2, 13'd16, 13'd16);
		quiet_run = 1'b1;
		sink_hold = 300;
		repeat (6) send_pixel($urandom);
		quiet_run = 1'b0;
	endtask

	// random settings, mostly whole frames with random colours
	task automatic test_random_frames();
		int sent, n, frame_len, i;
		sent = 0;
		while (sent < 420) begin
			quiet_run = ($urandom_range(0, 4) == 0);
			if (sent == 0 || $urandom_range(0, 3) != 0) begin
				configure(pick_dim(6), pick_dim(6), pick_dim(48), pick_dim(48));
			end else begin
				wait_idle();
				write_reg(iuc_pkg::reg_idx_t'($urandom_range(0, 3)), pick_dim(24));
			end
			if (dims_zero()) begin
				n = $urandom_range(2, 5);
			end else begin
				frame_len = int'(src_w) * int'(src_h);
				if (frame_len <= 40) begin
					n = frame_len * $urandom_range(1, 2) + $urandom_range(0, 2);
					if (n > 40) n = 40;
				end else begin
					n = $urandom_range(2, 8);
				end
			end
			for (i = 0; i < n; i++) send_pixel($urandom);
			sent += n;
		end
		quiet_run = 1'b0;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel_color = '0;
		src_w = '0;
		src_h = '0;
		dst_w = '0;
		dst_h = '0;
		col_pos = 0;
		row_pos = 0;
		scale_cur = 1;
		off_x = 0;
		off_y = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_zero_dims();
		test_basic_upscale();
		test_max_scale();
		test_shrunk_target();
		test_zero_mid_frame();
		test_backpressure();
		test_random_frames();

		wait_idle();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && pending_writes.size() == 0) begin
			$display("integer_upscale_centered regression: pass");
		end else begin
			$display("integer_upscale_centered regression: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20000000;
		$display("integer_upscale_centered regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
sv/iuc_pkg.sv
sv/integer_upscale_centered.sv
tb/integer_upscale_centered_test.sv
